@@ rtl/twg_pkg.sv @@
// Package for the time waveform generator: transaction payload types, codes
// and constants shared by the RTL.
// Depends on nothing.
package twg_pkg;

  // Default depth of the sample table.
  localparam int MaxSamplesDefault = 128;

  // Unsigned Q1.16 full scale.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Reset values of the configuration registers.
  localparam logic [1:0]  KIND_RESET     = 2'd0;
  localparam logic [15:0] PERIOD_RESET   = 16'd1000;
  localparam logic [15:0] DURATION_RESET = 16'd1000;
  localparam logic [7:0]  COUNT_RESET    = 8'd100;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KIND     = 2'd0;
  localparam logic [1:0] CFG_PERIOD   = 2'd1;
  localparam logic [1:0] CFG_DURATION = 2'd2;
  localparam logic [1:0] CFG_COUNT    = 2'd3;

  // Input action codes.
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_WRITE   = 2'd2;

  // Waveform kinds.
  localparam logic [1:0] KIND_TRIANGLE = 2'd0;
  localparam logic [1:0] KIND_RAMP     = 2'd1;
  localparam logic [1:0] KIND_SAMPLED  = 2'd2;

  // Shared divider: 32-bit dividend, 16-bit divisor, two quotient bits a cycle.
  localparam int DivW      = 32;
  localparam int DivCycles = DivW / 2;
  localparam int DivCntW   = $clog2(DivCycles);

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  sample_index;
    logic [16:0] sample_value;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [16:0] wave_value;
    logic        decayed;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_READ,
    ST_FETCH,
    ST_DONE
  } state_t;

  // What the current division computes.
  typedef enum logic [2:0] {
    OP_MOD,
    OP_UP,
    OP_DOWN,
    OP_RAMP,
    OP_IDX
  } op_t;

endpackage

@@ rtl/time_waveform_generator.sv @@
// Top level of the time waveform generator: elapsed counter, sample table,
// shared radix-4 restoring divider and its sequencer.
// Depends on twg_pkg.
//
//  Channel  Direction  Handshake                Payload
//  in_      input      in_valid / in_ready      twg_pkg::in_item_t
//  out_     output     out_valid / out_ready    twg_pkg::out_item_t
//  cfg_     input      cfg_write_en             cfg_index, cfg_data
//
// One transaction at a time; the divider retires two quotient bits a cycle.
// Triangle results take a modulo division and then a scaling division, ramp
// results one division, playback an index division plus a table read, and
// zero-duration playback a table read only; the decayed, zero-duration ramp
// and short-period cases need neither. The next input is taken in the cycle
// after the result is registered.
// Reset is synchronous and active low; the sample table is not cleared.
// A finished result waits in the output register while the next input is taken;
// a second result waits in the sequencer until the output register is free.
module time_waveform_generator #(
  parameter int MAX_SAMPLES = twg_pkg::MaxSamplesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  twg_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output twg_pkg::out_item_t  out_data,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int PW = 16 + IW;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_SAMPLES - 1);
  localparam int CW = twg_pkg::DivCntW;
  localparam logic [CW-1:0] CNT_LAST = CW'(twg_pkg::DivCycles - 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  // Configuration registers.
  logic [1:0]  kind_r;
  logic [15:0] period_r;
  logic [15:0] duration_r;
  logic [7:0]  count_r;

  // Control and datapath registers.
  twg_pkg::state_t state_r, state_nxt;
  twg_pkg::op_t    op_r, op_nxt;
  logic [31:0]     elapsed_r, elapsed_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [15:0]     rem_r, rem_nxt;
  logic [31:0]     quo_r, quo_nxt;
  logic [15:0]     div_r, div_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [16:0]     res_value_r, res_value_nxt;
  logic            res_decayed_r, res_decayed_nxt;
  logic            out_valid_r, out_valid_nxt;
  twg_pkg::out_item_t out_data_r, out_data_nxt;

  // Sample table and its registered read port.
  logic [16:0] table_mem [MAX_SAMPLES];
  logic [16:0] rd_data_r;
  logic        wr_en;
  logic [IW-1:0] wr_addr;

  // Divider step and helper values.
  logic [16:0] r1, r2;
  logic        ge1, ge2;
  logic [15:0] rem1, rem2;
  logic [15:0] half;
  logic [IW-1:0] n_m1;
  logic [PW-1:0] prod;
  logic        accept;

  assign in_ready  = (state_r == twg_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= twg_pkg::KIND_RESET;
      period_r   <= twg_pkg::PERIOD_RESET;
      duration_r <= twg_pkg::DURATION_RESET;
      count_r    <= twg_pkg::COUNT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        twg_pkg::CFG_KIND:     kind_r     <= cfg_data[1:0];
        twg_pkg::CFG_PERIOD:   period_r   <= cfg_data;
        twg_pkg::CFG_DURATION: duration_r <= cfg_data;
        twg_pkg::CFG_COUNT:    count_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Table write at input acceptance, registered read every cycle.
  assign wr_en   = accept && (in_data.action == twg_pkg::ACT_WRITE) &&
                   ({25'b0, in_data.sample_index} < 32'(MAX_SAMPLES));
  assign wr_addr = IW'({25'b0, in_data.sample_index});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= in_data.sample_value;
    end
    rd_data_r <= table_mem[idx_r];
  end

  // Two restoring division steps per cycle.
  always_comb begin
    r1   = {rem_r, quo_r[31]};
    ge1  = (r1 >= {1'b0, div_r});
    rem1 = ge1 ? 16'(r1 - {1'b0, div_r}) : r1[15:0];
    r2   = {rem1, quo_r[30]};
    ge2  = (r2 >= {1'b0, div_r});
    rem2 = ge2 ? 16'(r2 - {1'b0, div_r}) : r2[15:0];
  end

  // Half period, last sample index in use, and the playback index product.
  always_comb begin
    half = {1'b0, period_r[15:1]};
    if (count_r == 8'd0) begin
      n_m1 = '0;
    end else if ({24'b0, count_r} > 32'(MAX_SAMPLES)) begin
      n_m1 = IDX_LAST;
    end else begin
      n_m1 = IW'({24'b0, count_r} - 32'd1);
    end
    prod = PW'(elapsed_r[15:0]) * PW'(n_m1);
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    elapsed_nxt     = elapsed_r;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    div_nxt         = div_r;
    idx_nxt         = idx_r;
    res_value_nxt   = res_value_r;
    res_decayed_nxt = res_decayed_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;

    // The output register empties on a completed result transaction.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      twg_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            twg_pkg::ACT_TICK: begin
              if (elapsed_r != 32'hFFFF_FFFF) begin
                elapsed_nxt = elapsed_r + 32'd1;
              end
            end
            twg_pkg::ACT_RESTART: elapsed_nxt = '0;
            default: ;
          endcase
          state_nxt = twg_pkg::ST_PREP;
        end
      end

      // Decide the case and load the divider if one is needed.
      twg_pkg::ST_PREP: begin
        res_value_nxt   = '0;
        res_decayed_nxt = 1'b0;
        rem_nxt         = '0;
        cnt_nxt         = '0;
        state_nxt       = twg_pkg::ST_DONE;
        case (kind_r)
          twg_pkg::KIND_TRIANGLE: begin
            if (half != 16'd0) begin
              quo_nxt   = elapsed_r;
              div_nxt   = period_r;
              op_nxt    = twg_pkg::OP_MOD;
              state_nxt = twg_pkg::ST_DIV;
            end
          end
          twg_pkg::KIND_RAMP: begin
            if (elapsed_r > {16'b0, duration_r}) begin
              res_decayed_nxt = 1'b1;
            end else if (duration_r == 16'd0) begin
              res_value_nxt = twg_pkg::ONE_Q16;
            end else begin
              quo_nxt   = {elapsed_r[15:0], 16'b0};
              div_nxt   = duration_r;
              op_nxt    = twg_pkg::OP_RAMP;
              state_nxt = twg_pkg::ST_DIV;
            end
          end
          twg_pkg::KIND_SAMPLED: begin
            if (elapsed_r > {16'b0, duration_r}) begin
              res_decayed_nxt = 1'b1;
            end else if (duration_r == 16'd0) begin
              idx_nxt   = n_m1;
              state_nxt = twg_pkg::ST_READ;
            end else begin
              quo_nxt   = 32'(prod);
              div_nxt   = duration_r;
              op_nxt    = twg_pkg::OP_IDX;
              state_nxt = twg_pkg::ST_DIV;
            end
          end
          default: res_decayed_nxt = 1'b1;
        endcase
      end

      // Shared divider iterations.
      twg_pkg::ST_DIV: begin
        rem_nxt = rem2;
        quo_nxt = {quo_r[29:0], ge1, ge2};
        cnt_nxt = cnt_r + CNT_ONE;
        if (cnt_r == CNT_LAST) begin
          state_nxt = twg_pkg::ST_FIN;
        end
      end

      // Interpret the finished division.
      twg_pkg::ST_FIN: begin
        state_nxt = twg_pkg::ST_DONE;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        unique case (op_r) inside
          twg_pkg::OP_MOD: begin
            div_nxt   = half;
            state_nxt = twg_pkg::ST_DIV;
            if (rem_r <= half) begin
              quo_nxt = {rem_r, 16'b0};
              op_nxt  = twg_pkg::OP_UP;
            end else begin
              quo_nxt = {16'(rem_r - half), 16'b0};
              op_nxt  = twg_pkg::OP_DOWN;
            end
          end
          twg_pkg::OP_UP, twg_pkg::OP_RAMP: begin
            res_value_nxt = quo_r[16:0];
          end
          twg_pkg::OP_DOWN: begin
            if (quo_r > {15'b0, twg_pkg::ONE_Q16}) begin
              res_value_nxt = '0;
            end else begin
              res_value_nxt = twg_pkg::ONE_Q16 - quo_r[16:0];
            end
          end
          twg_pkg::OP_IDX: begin
            idx_nxt   = (quo_r > 32'(n_m1)) ? n_m1 : IW'(quo_r);
            state_nxt = twg_pkg::ST_READ;
          end
          default: ;
        endcase
      end

      // The table read address settles; the registered read data arrives in ST_FETCH.
      twg_pkg::ST_READ: begin
        state_nxt = twg_pkg::ST_FETCH;
      end

      twg_pkg::ST_FETCH: begin
        res_value_nxt = rd_data_r;
        state_nxt     = twg_pkg::ST_DONE;
      end

      // Hand the result to the output register once it is free.
      twg_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.wave_value = res_value_r;
          out_data_nxt.decayed    = res_decayed_r;
          state_nxt               = twg_pkg::ST_IDLE;
        end
      end

      default: state_nxt = twg_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    cnt_r         <= cnt_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    div_r         <= div_nxt;
    idx_r         <= idx_nxt;
    res_value_r   <= res_value_nxt;
    res_decayed_r <= res_decayed_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule
